// ===== design/ogr_pkg.sv =====
// Shared types and constants for the occupancy grid ray update block.
// Holds opcodes, register indexes and the configuration struct.
// No dependencies.
`timescale 1ns / 1ps

package ogr_pkg;

    localparam int LEVEL_W = 16;
    localparam int MAX_WALK = 32;

    typedef enum logic [1:0] {
        OP_OCCUPIED = 2'd0,
        OP_EMPTY    = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_NOP      = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        REG_EMPTY_STEP    = 3'd0,
        REG_OCCUPIED_STEP = 3'd1,
        REG_FLOOR_LEVEL   = 3'd2,
        REG_CEILING_LEVEL = 3'd3,
        REG_PRIOR_LEVEL   = 3'd4,
        REG_RAY_END       = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic signed [15:0] empty_step;
        logic        [14:0] occupied_step;
        logic signed [15:0] floor_level;
        logic        [14:0] ceiling_level;
        logic signed [15:0] prior_level;
        logic        [5:0]  ray_end;
    } cfg_t;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] hit;
        logic [4:0] z;
    } cell_ctl_t;

endpackage

// ===== design/occupancy_ray_log_odds_update.sv =====
// Occupancy grid ray update: walks one grid column per item, one cell per cycle
// while the output side is not stalled. A new item is taken only once the previous
// walk has drained from the read stage; the output register may still hold its last cell.
// The single grid memory port pair (one read, one write per cycle) sets the rate.
// Reset clears control and loads the register defaults; the grid is not cleared.
// Depends on ogr_pkg, ogr_ram and ogr_cell_alu.
`timescale 1ns / 1ps

module occupancy_ray_log_odds_update #(
    parameter int GRID_X = 64,
    parameter int GRID_Y = 64,
    parameter int GRID_Z = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [5:0]         ray_x,
    input  logic [5:0]         ray_y,
    input  logic [4:0]         hit_depth,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [4:0]         cell_depth,
    output logic signed [15:0] level,
    output logic               last
);
    import ogr_pkg::*;

    localparam int CELLS  = GRID_X * GRID_Y * GRID_Z;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int WALK_MAX = (GRID_Z < MAX_WALK) ? GRID_Z : MAX_WALK;

    cfg_t cfg_reg;

    logic              walk_reg;
    logic [1:0]        op_reg;
    logic [4:0]        hit_reg;
    logic [5:0]        len_reg;
    logic [4:0]        z_reg;
    logic [ADDR_W-1:0] base_reg;

    logic              s2_valid_reg;
    logic [4:0]        s2_z_reg;
    logic              s2_last_reg;
    logic [ADDR_W-1:0] s2_addr_reg;

    logic              out_valid_reg;
    logic [4:0]        out_depth_reg;
    logic signed [15:0] out_level_reg;
    logic              out_last_reg;

    logic              in_fire;
    logic              out_free;
    logic              s2_adv;
    logic              rd_en;
    logic              rd_last;
    logic [ADDR_W-1:0] rd_addr;
    logic [5:0]        len_next;
    logic [ADDR_W-1:0] base_next;
    logic [31:0]       x_sat;
    logic [31:0]       y_sat;
    logic [15:0]       rd_data;
    logic signed [15:0] new_level;
    cell_ctl_t         ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.empty_step    <= -16'sd8192;
            cfg_reg.occupied_step <= 15'd8192;
            cfg_reg.floor_level   <= -16'sd8173;
            cfg_reg.ceiling_level <= 15'd8173;
            cfg_reg.prior_level   <= -16'sd6010;
            cfg_reg.ray_end       <= 6'd32;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_EMPTY_STEP:    cfg_reg.empty_step    <= $signed(cfg_data);
                REG_OCCUPIED_STEP: cfg_reg.occupied_step <= cfg_data[14:0];
                REG_FLOOR_LEVEL:   cfg_reg.floor_level   <= $signed(cfg_data);
                REG_CEILING_LEVEL: cfg_reg.ceiling_level <= cfg_data[14:0];
                REG_PRIOR_LEVEL:   cfg_reg.prior_level   <= $signed(cfg_data);
                REG_RAY_END:       cfg_reg.ray_end       <= cfg_data[5:0];
                default:           ;
            endcase
        end
    end

    // column address and walk length
    always_comb
    begin
        x_sat = (32'(ray_x) >= 32'(GRID_X)) ? 32'(GRID_X - 1) : 32'(ray_x);
        y_sat = (32'(ray_y) >= 32'(GRID_Y)) ? 32'(GRID_Y - 1) : 32'(ray_y);
        base_next = ADDR_W'((x_sat * 32'(GRID_Y) + y_sat) * 32'(GRID_Z));
        len_next = (32'(cfg_reg.ray_end) > 32'(WALK_MAX)) ? 6'(WALK_MAX) : cfg_reg.ray_end;
    end

    assign out_free = !out_valid_reg || out_ready;
    assign s2_adv   = s2_valid_reg && out_free;
    assign in_ready = !walk_reg && !s2_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign rd_en    = walk_reg && (!s2_valid_reg || s2_adv);
    assign rd_addr  = base_reg + ADDR_W'(z_reg);
    assign rd_last  = ({1'b0, z_reg} + 6'd1) == len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg      <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            z_reg         <= 5'd0;
        end
        else
        begin
            if (in_fire)
            begin
                walk_reg <= (len_next != 6'd0);
                z_reg    <= 5'd0;
            end
            else if (rd_en)
            begin
                walk_reg <= !rd_last;
                z_reg    <= z_reg + 5'd1;
            end
            if (rd_en)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= opcode;
            hit_reg  <= hit_depth;
            len_reg  <= len_next;
            base_reg <= base_next;
        end
        if (rd_en)
        begin
            s2_z_reg    <= z_reg;
            s2_last_reg <= rd_last;
            s2_addr_reg <= rd_addr;
        end
        if (s2_adv)
        begin
            out_depth_reg <= s2_z_reg;
            out_level_reg <= new_level;
            out_last_reg  <= s2_last_reg;
        end
    end

    assign ctl.op  = op_reg;
    assign ctl.hit = hit_reg;
    assign ctl.z   = s2_z_reg;

    ogr_ram #(
        .WIDTH  (LEVEL_W),
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_grid (
        .clk   (clk),
        .we    (s2_adv),
        .waddr (s2_addr_reg),
        .wdata (new_level),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    ogr_cell_alu u_alu (
        .cfg       (cfg_reg),
        .ctl       (ctl),
        .level_in  ($signed(rd_data)),
        .level_out (new_level)
    );

    assign out_valid  = out_valid_reg;
    assign cell_depth = out_depth_reg;
    assign level      = out_level_reg;
    assign last       = out_last_reg;

    // never read while a fetched cell is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !(s2_valid_reg && !s2_adv))
        else $error("grid read issued over a stalled cell");

    // write-back and read never hit the same cell
    assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && s2_adv) |-> (rd_addr != s2_addr_reg))
        else $error("grid read and write collide");

    // a new item only starts on a drained walk
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (!walk_reg && !s2_valid_reg))
        else $error("item taken while walk in flight");

    // last cell ends the walk
    assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && rd_last) |=> !walk_reg)
        else $error("walk continues past last cell");

endmodule

// ===== design/ogr_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds while read enable is low. No dependencies.
`timescale 1ns / 1ps

module ogr_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/ogr_cell_alu.sv =====
// Per-cell log-odds update with floor and ceiling clamps, or a clear to the prior level.
// Depends on ogr_pkg.
`timescale 1ns / 1ps

module ogr_cell_alu (
    input  ogr_pkg::cfg_t             cfg,
    input  ogr_pkg::cell_ctl_t        ctl,
    input  logic signed [15:0]        level_in,
    output logic signed [15:0]        level_out
);
    import ogr_pkg::*;

    logic signed [17:0] empty_sum;
    logic signed [17:0] occ_sum;
    logic signed [15:0] empty_res;
    logic signed [15:0] occ_res;

    always_comb
    begin
        empty_sum = 18'(level_in) + 18'(cfg.empty_step);
        occ_sum   = 18'(level_in) + $signed({3'b000, cfg.occupied_step});
        if (empty_sum < 18'(cfg.floor_level))
        begin
            empty_res = cfg.floor_level;
        end
        else if (empty_sum > 18'sd32767)
        begin
            empty_res = 16'sh7FFF;
        end
        else
        begin
            empty_res = empty_sum[15:0];
        end
        if (occ_sum > $signed({3'b000, cfg.ceiling_level}))
        begin
            occ_res = $signed({1'b0, cfg.ceiling_level});
        end
        else
        begin
            occ_res = occ_sum[15:0];
        end
    end

    always_comb
    begin
        level_out = level_in;
        case (opcode_t'(ctl.op))
            OP_CLEAR:    level_out = cfg.prior_level;
            OP_EMPTY:    level_out = empty_res;
            OP_OCCUPIED:
            begin
                if (ctl.z < ctl.hit)
                begin
                    level_out = empty_res;
                end
                else if (ctl.z == ctl.hit)
                begin
                    level_out = occ_res;
                end
            end
            default:     level_out = level_in;
        endcase
    end

endmodule
